/* design/anqp_pkg.sv */
// Package for the ANQP element deframer: item types and byte codes.
// It depends on nothing; the deframer top level imports it.
`timescale 1ns / 1ps

package anqp_pkg;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;
  localparam logic [1:0] KIND_OVERRUN = 2'd3;

  localparam logic [7:0] WFA_OUI_0 = 8'h50;
  localparam logic [7:0] WFA_OUI_1 = 8'h6F;
  localparam logic [7:0] WFA_OUI_2 = 8'h9A;
  localparam logic [7:0] HS_TYPE   = 8'h11;

  localparam logic [15:0] HDR_LEN     = 16'd4;
  localparam logic [15:0] HS_MIN_LEN  = 16'd6;
  localparam logic [15:0] OUI_LEN     = 16'd3;
  localparam logic [15:0] SUBTYPE_OFF = 16'd4;

  typedef struct packed {
    logic        first_byte;
    logic [15:0] buffer_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [15:0] element_id;
    logic [15:0] element_length;
    logic [15:0] payload_offset;
    logic        element_end;
    logic [7:0]  payload_byte;
    logic        is_hotspot;
    logic [7:0]  hotspot_subtype;
  } out_item_t;

endpackage

/* design/anqp_element_deframer_top.sv */
// Top level of the ANQP element deframer: parser state and result register.
// It depends on anqp_pkg for the item types and byte codes.
`timescale 1ns / 1ps

// The deframer takes one byte of an ANQP response buffer per item and returns
// one result item per byte, in the cycle after the byte is accepted. A byte is
// taken in every cycle in which the result register is empty or its item is
// being taken at the same edge, so the sustained rate is one byte per clock.
// That figure is set by the single parser update, a few compares and a 16-bit
// counter step, that sits between the input port and the result register.
// Parsing restarts on every byte marked as the first of a buffer.
module anqp_element_deframer_top
  import anqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] position_q, position_d;
  logic [15:0] total_q, total_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] cur_id_q, cur_id_d;
  logic [15:0] cur_len_q, cur_len_d;
  logic [15:0] pay_cnt_q, pay_cnt_d;
  logic        vendor_q, vendor_d;
  logic [7:0]  subtype_q, subtype_d;
  logic        out_valid_q;
  out_item_t   out_item_q, res_d;
  logic        accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    logic [15:0] pos;
    logic [16:0] next_pos;
    logic [17:0] next_hdr_end;
    logic [17:0] elem_end;
    logic        next_fits;
    logic [7:0]  b;
    phase_e      ph;
    logic        vm;

    b         = in_item_i.data_byte;
    total_d   = total_q;
    pos       = position_q;
    ph        = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    if (in_item_i.first_byte) begin
      total_d   = in_item_i.buffer_length;
      pos       = '0;
      hdr_cnt_d = '0;
      ph        = (HDR_LEN <= in_item_i.buffer_length) ? PH_HEADER : PH_STOPPED;
    end

    next_pos     = {1'b0, pos} + 17'd1;
    next_hdr_end = {1'b0, next_pos} + {2'b00, HDR_LEN};
    next_fits    = next_hdr_end <= {2'b00, total_d};

    phase_d   = ph;
    cur_id_d  = cur_id_q;
    cur_len_d = cur_len_q;
    pay_cnt_d = pay_cnt_q;
    vendor_d  = vendor_q;
    subtype_d = subtype_q;
    elem_end  = '0;
    vm        = 1'b0;

    res_d                 = '0;
    res_d.byte_kind       = KIND_IGNORED;
    res_d.payload_byte    = b;

    unique case (ph)
      PH_HEADER: begin
        unique case (hdr_cnt_d)
          2'd0: begin
            cur_id_d  = {8'h00, b};
            cur_len_d = '0;
          end
          2'd1: cur_id_d = {b, cur_id_q[7:0]};
          2'd2: cur_len_d = {8'h00, b};
          default: cur_len_d = {b, cur_len_q[7:0]};
        endcase
        res_d.byte_kind      = KIND_HEADER;
        res_d.element_id     = cur_id_d;
        res_d.element_length = cur_len_d;
        if (hdr_cnt_d == 2'd3) begin
          hdr_cnt_d = '0;
          elem_end  = {1'b0, next_pos} + {2'b00, cur_len_d};
          if (elem_end > {2'b00, total_d}) begin
            res_d.byte_kind = KIND_OVERRUN;
            phase_d         = PH_STOPPED;
          end else if (cur_len_d == '0) begin
            res_d.element_end = 1'b1;
            phase_d           = next_fits ? PH_HEADER : PH_STOPPED;
          end else begin
            phase_d   = PH_PAYLOAD;
            pay_cnt_d = '0;
            vendor_d  = cur_len_d >= HS_MIN_LEN;
            subtype_d = '0;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_d + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        res_d.byte_kind      = KIND_PAYLOAD;
        res_d.element_id     = cur_id_q;
        res_d.element_length = cur_len_q;
        res_d.payload_offset = pay_cnt_q;
        vm = vendor_q;
        priority if (pay_cnt_q == 16'd0) begin
          if (b != WFA_OUI_0) vm = 1'b0;
        end else if (pay_cnt_q == 16'd1) begin
          if (b != WFA_OUI_1) vm = 1'b0;
        end else if (pay_cnt_q == 16'd2) begin
          if (b != WFA_OUI_2) vm = 1'b0;
        end else if (pay_cnt_q == OUI_LEN) begin
          if (b != HS_TYPE) vm = 1'b0;
        end else if (pay_cnt_q == SUBTYPE_OFF) begin
          subtype_d = b;
        end
        vendor_d = vm;
        if (vm && (pay_cnt_q >= HS_MIN_LEN)) begin
          res_d.is_hotspot      = 1'b1;
          res_d.hotspot_subtype = subtype_d;
        end
        if (({1'b0, pay_cnt_q} + 17'd1) >= {1'b0, cur_len_q}) begin
          res_d.element_end = 1'b1;
          hdr_cnt_d         = '0;
          phase_d           = next_fits ? PH_HEADER : PH_STOPPED;
        end else begin
          pay_cnt_d = pay_cnt_q + 16'd1;
        end
      end
      default: phase_d = PH_STOPPED;
    endcase

    position_d = (pos == 16'hFFFF) ? pos : next_pos[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STOPPED;
      position_q  <= '0;
      total_q     <= '0;
      hdr_cnt_q   <= '0;
      cur_id_q    <= '0;
      cur_len_q   <= '0;
      pay_cnt_q   <= '0;
      vendor_q    <= 1'b0;
      subtype_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        position_q <= position_d;
        total_q    <= total_d;
        hdr_cnt_q  <= hdr_cnt_d;
        cur_id_q   <= cur_id_d;
        cur_len_q  <= cur_len_d;
        pay_cnt_q  <= pay_cnt_d;
        vendor_q   <= vendor_d;
        subtype_q  <= subtype_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= res_d;
    end
  end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the ANQP element deframer top level.
// It needs anqp_pkg and anqp_element_deframer_top; it predicts one report per byte
// with its own parser model and compares every field of every report item.
`timescale 1ns / 1ps

module tb;
  import anqp_pkg::*;

  typedef enum logic [1:0] {PH_STOPPED, PH_HEADER, PH_PAYLOAD} parse_phase_e;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } stream_entry_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  stream_entry_t byte_stream[$];
  out_item_t     byte_reports[$];
  logic [7:0]    frame_bytes[$];

  logic [15:0]  cur_pos = '0;
  logic [15:0]  tot_len = '0;
  parse_phase_e phase = PH_STOPPED;
  logic [1:0]   hdr_cnt = '0;
  logic [15:0]  cur_id = '0;
  logic [15:0]  cur_len = '0;
  logic [15:0]  pay_cnt = '0;
  bit           hs_match = 1'b0;
  logic [7:0]   hs_subtype = '0;
  logic [7:0]   wfa_oui[3] = '{WFA_OUI_0, WFA_OUI_1, WFA_OUI_2};

  int unsigned gap_left = 0;
  int unsigned hold_n;
  int unsigned stall_left = 0;
  int unsigned stall_n;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;
  bit          drain_next = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned parsed_cnt = 0;
  out_item_t   want;

  anqp_element_deframer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #4 clk_i = ~clk_i;

  function automatic void elem_start(int unsigned nxt);
    hdr_cnt = 2'd0;
    phase = (nxt + HDR_LEN <= tot_len) ? PH_HEADER : PH_STOPPED;
  endfunction

  function automatic void deframe_byte(in_item_t it);
    out_item_t   r;
    int unsigned pos;
    logic [15:0] off;
    logic [7:0]  b;
    b = it.data_byte;
    r = '0;
    r.byte_kind = KIND_IGNORED;
    r.payload_byte = b;
    pos = cur_pos;
    if (it.first_byte) begin
      tot_len = it.buffer_length;
      cur_pos = '0;
      pos = 0;
      elem_start(0);
    end
    case (phase)
      PH_HEADER: begin
        case (hdr_cnt)
          2'd0: begin
            cur_id = {8'h00, b};
            cur_len = '0;
          end
          2'd1: cur_id[15:8] = b;
          2'd2: cur_len = {8'h00, b};
          default: cur_len[15:8] = b;
        endcase
        r.byte_kind = KIND_HEADER;
        r.element_id = cur_id;
        r.element_length = cur_len;
        if (hdr_cnt == 2'd3) begin
          hdr_cnt = 2'd0;
          if (pos + 32'd1 + cur_len > tot_len) begin
            r.byte_kind = KIND_OVERRUN;
            phase = PH_STOPPED;
          end else if (cur_len == 16'd0) begin
            r.element_end = 1'b1;
            elem_start(pos + 1);
          end else begin
            phase = PH_PAYLOAD;
            pay_cnt = '0;
            hs_match = (cur_len >= HS_MIN_LEN);
            hs_subtype = '0;
          end
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        off = pay_cnt;
        r.byte_kind = KIND_PAYLOAD;
        r.element_id = cur_id;
        r.element_length = cur_len;
        r.payload_offset = off;
        if (off < OUI_LEN) begin
          if (b != wfa_oui[off]) hs_match = 1'b0;
        end else if (off == OUI_LEN) begin
          if (b != HS_TYPE) hs_match = 1'b0;
        end else if (off == SUBTYPE_OFF) begin
          hs_subtype = b;
        end
        if (hs_match && off >= HS_MIN_LEN) begin
          r.is_hotspot = 1'b1;
          r.hotspot_subtype = hs_subtype;
        end
        if (off + 32'd1 >= cur_len) begin
          r.element_end = 1'b1;
          elem_start(pos + 1);
        end else begin
          pay_cnt = off + 16'd1;
        end
      end
      default: phase = PH_STOPPED;
    endcase
    if (cur_pos != 16'hFFFF) cur_pos = cur_pos + 16'd1;
    byte_reports.push_back(r);
  endfunction

  task automatic cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  task automatic add_byte(bit first, logic [15:0] blen, logic [7:0] data);
    stream_entry_t e;
    if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
    e.item.first_byte = first;
    e.item.buffer_length = blen;
    e.item.data_byte = data;
    e.gap = tx_calm ? 0 : $urandom_range(0, 13);
    e.drain = drain_next;
    drain_next = 1'b0;
    byte_stream.push_back(e);
  endtask

  task automatic send_frame(logic [15:0] total, int unsigned count);
    for (int i = 0; i < count; i++) begin
      add_byte(i == 0, (i == 0) ? total : 16'($urandom_range(0, 65535)), frame_bytes[i]);
    end
  endtask

  task automatic build_random_buffer();
    int unsigned n_el, pick, base, total, variant, count;
    logic [15:0] eid, elen;
    frame_bytes.delete();
    n_el = $urandom_range(1, 4);
    for (int e = 0; e < n_el; e++) begin
      pick = $urandom_range(0, 9);
      eid = 16'($urandom_range(0, 65535));
      if (pick == 9) elen = 16'($urandom_range(0, 65535));
      else if (pick < 3) elen = 16'($urandom_range(6, 12));
      else if (pick == 3) elen = 16'd0;
      else if (pick == 4) elen = 16'($urandom_range(4, 5));
      else elen = 16'($urandom_range(1, 10));
      frame_bytes.push_back(eid[7:0]);
      frame_bytes.push_back(eid[15:8]);
      frame_bytes.push_back(elen[7:0]);
      frame_bytes.push_back(elen[15:8]);
      if (pick != 9) begin
        for (int k = 0; k < elen; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (pick < 5) begin
          base = frame_bytes.size() - elen;
          frame_bytes[base] = WFA_OUI_0;
          frame_bytes[base + 1] = WFA_OUI_1;
          frame_bytes[base + 2] = WFA_OUI_2;
          frame_bytes[base + 3] = HS_TYPE;
          if (pick == 2) begin
            base = base + $urandom_range(0, 3);
            frame_bytes[base] = frame_bytes[base] ^ (8'h01 << $urandom_range(0, 7));
          end
        end
      end
    end
    total = frame_bytes.size();
    variant = $urandom_range(0, 9);
    if (variant == 6) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      total = frame_bytes.size();
    end else if (variant == 7) begin
      total = total - $urandom_range(1, total - 1);
    end
    count = frame_bytes.size();
    if (variant == 8) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      count = frame_bytes.size();
    end else if (variant == 9) begin
      count = $urandom_range(1, count);
    end
    send_frame(16'(total), count);
    parsed_cnt += (count < total) ? count : total;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_item);
        hold_n = (byte_stream.size() != 0) ? byte_stream[0].gap : 0;
      end else begin
        hold_n = gap_left;
      end
      if (in_valid && !in_ready) begin
        gap_left <= 0;
      end else if (hold_n != 0) begin
        in_valid <= 1'b0;
        gap_left <= hold_n - 1;
      end else if (byte_stream.size() != 0 &&
                   !(byte_stream[0].drain && byte_reports.size() != 0)) begin
        in_valid <= 1'b1;
        in_item <= byte_stream[0].item;
        void'(byte_stream.pop_front());
        gap_left <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_left <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (byte_reports.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
        fail_cnt++;
      end else begin
        want = byte_reports.pop_front();
        cmp_field("byte_kind", want.byte_kind, out_item.byte_kind);
        cmp_field("element_id", want.element_id, out_item.element_id);
        cmp_field("element_length", want.element_length, out_item.element_length);
        cmp_field("payload_offset", want.payload_offset, out_item.payload_offset);
        cmp_field("element_end", want.element_end, out_item.element_end);
        cmp_field("payload_byte", want.payload_byte, out_item.payload_byte);
        cmp_field("is_hotspot", want.is_hotspot, out_item.is_hotspot);
        cmp_field("hotspot_subtype", want.hotspot_subtype, out_item.hotspot_subtype);
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      stall_n = rx_calm ? 0 : $urandom_range(0, 13);
      out_ready <= (stall_n == 0);
      stall_left <= (stall_n == 0) ? 0 : stall_n - 1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    add_byte(1'b0, 16'd12, 8'hA5);
    add_byte(1'b1, 16'd3, 8'h01);
    add_byte(1'b0, 16'd0, 8'h02);
    add_byte(1'b1, 16'd0, 8'hFF);
    frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    send_frame(16'd4, 5);
    frame_bytes = '{8'h34, 8'h12, 8'h08, 8'h00, 8'h50, 8'h6F, 8'h9A, 8'h11,
                    8'h05, 8'h00, 8'hAA, 8'hBB};
    send_frame(16'd12, 12);
    frame_bytes = '{8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00};
    send_frame(16'hFFFF, 5);
    drain_next = 1'b1;
    for (int iter = 0; parsed_cnt < 1250; iter++) begin
      if (iter == 60) drain_next = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        add_byte(1'($urandom_range(0, 1)), ($urandom_range(0, 1) != 0) ?
                 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 24)),
                 8'($urandom_range(0, 255)));
      end else begin
        build_random_buffer();
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (byte_stream.size() != 0 || in_valid);
    while (byte_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("anqp_element_deframer_top test passed");
    end else begin
      $display("anqp_element_deframer_top test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("anqp_element_deframer_top test failed");
    $finish;
  end

endmodule

/* filelist.f */
design/anqp_pkg.sv
design/anqp_element_deframer_top.sv
tb/tb.sv
